@@ rtl/tss_pkg.sv @@
// ----------------------------------------------------------------------------
// tss_pkg: shared types and constants for the triangle scanline span block
// Coordinate widths, the request and result payloads and the record that
// travels down the divider chain.
// ----------------------------------------------------------------------------
package tss_pkg;

  localparam int COORD_BITS = 12;
  localparam int DIFF_W     = COORD_BITS + 1;      // difference of two coords
  localparam int PROD_W     = 2 * COORD_BITS + 2;  // product of two differences
  localparam int SUM_W      = 2 * COORD_BITS + 3;  // signed numerator
  localparam int MAG_W      = SUM_W;               // numerator magnitude, quotient
  localparam int DEN_W      = COORD_BITS;          // sorted edges have den >= 0
  localparam int REM_W      = COORD_BITS + 1;      // partial remainder
  localparam int VAL_W      = MAG_W + 1;           // signed quotient
  localparam int NUM_CELLS  = MAG_W;               // one quotient bit per cell

  localparam logic signed [VAL_W-1:0] SAT_HI = VAL_W'((2 ** (COORD_BITS - 1)) - 1);
  localparam logic signed [VAL_W-1:0] SAT_LO = VAL_W'(-(2 ** (COORD_BITS - 1)));

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } vertex_t;

  typedef struct packed {
    coord_t vertex_one_x;
    coord_t vertex_one_y;
    coord_t vertex_two_x;
    coord_t vertex_two_y;
    coord_t vertex_three_x;
    coord_t vertex_three_y;
    coord_t scan_row;
  } req_t;

  typedef struct packed {
    logic   row_inside;
    coord_t long_edge_x;
    coord_t short_edge_x;
  } res_t;

  // One edge's division in flight: numerator bits shift out at the top while
  // quotient bits shift in at the bottom of nq.
  typedef struct packed {
    logic [MAG_W-1:0] nq;
    logic [REM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic             neg;
    logic             zero;
    coord_t           x0;
  } lane_t;

  typedef struct packed {
    logic  valid;
    logic  row_in;
    lane_t long_lane;
    lane_t short_lane;
  } pipe_t;

endpackage

@@ rtl/tss_in_if.sv @@
// ----------------------------------------------------------------------------
// tss_in_if: request channel
// Valid/ready handshake carrying three vertices and a scanline row.
// ----------------------------------------------------------------------------
interface tss_in_if;
  import tss_pkg::*;
  logic valid;
  logic ready;
  req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/tss_out_if.sv @@
// ----------------------------------------------------------------------------
// tss_out_if: result channel
// Valid/ready handshake carrying the row flag and both span endpoints.
// ----------------------------------------------------------------------------
interface tss_out_if;
  import tss_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/tss_front.sv @@
// ----------------------------------------------------------------------------
// tss_front: vertex sort, edge setup and numerator formation
// Three stages: sort, multiply, sum and take magnitude.
// ----------------------------------------------------------------------------
module tss_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  logic           in_valid,
  input  tss_pkg::req_t  in_req,
  output tss_pkg::pipe_t out_pipe
);
  import tss_pkg::*;

  // Stage 1: sorted vertices
  logic    s1_valid;
  vertex_t s1_a, s1_b, s1_c;
  coord_t  s1_row;
  vertex_t a0, b0, c0, a1, b1, c1, a2, b2, c2;

  always_comb begin
    a0 = '{x: in_req.vertex_one_x,   y: in_req.vertex_one_y};
    b0 = '{x: in_req.vertex_two_x,   y: in_req.vertex_two_y};
    c0 = '{x: in_req.vertex_three_x, y: in_req.vertex_three_y};
    a1 = a0; b1 = b0;
    if (b0.y < a0.y) begin
      a1 = b0; b1 = a0;
    end
    a2 = a1; c1 = c0;
    if (c0.y < a1.y) begin
      a2 = c0; c1 = a1;
    end
    b2 = b1; c2 = c1;
    if (c1.y < b1.y) begin
      b2 = c1; c2 = b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_a   <= a2;
      s1_b   <= b2;
      s1_c   <= c2;
      s1_row <= in_req.scan_row;
    end
  end

  // Stage 2: edge selection and products
  typedef struct packed {
    logic signed [PROD_W-1:0] p0;
    logic signed [PROD_W-1:0] p1;
    logic [DEN_W-1:0]         den;
    coord_t                   x0;
  } prod_t;

  logic  s2_valid, s2_inside;
  prod_t s2_long, s2_short;
  prod_t long_c, short_c;
  logic  inside_c;

  function automatic prod_t edge_setup(vertex_t v0, vertex_t v1, coord_t row);
    logic signed [DIFF_W-1:0] den_s, dx, dr, x0e;
    prod_t r;
    den_s = DIFF_W'(v1.y) - DIFF_W'(v0.y);
    dx    = DIFF_W'(v1.x) - DIFF_W'(v0.x);
    dr    = DIFF_W'(row)  - DIFF_W'(v0.y);
    x0e   = DIFF_W'(v0.x);
    r.p0  = PROD_W'(x0e) * PROD_W'(den_s);
    r.p1  = PROD_W'(dx) * PROD_W'(dr);
    r.den = den_s[DEN_W-1:0];
    r.x0  = v0.x;
    return r;
  endfunction

  always_comb begin
    long_c = edge_setup(s1_a, s1_c, s1_row);
    if (s1_row < s1_b.y) begin
      short_c = edge_setup(s1_a, s1_b, s1_row);
    end else begin
      short_c = edge_setup(s1_b, s1_c, s1_row);
    end
    inside_c = (s1_row >= s1_a.y) && (s1_row <= s1_c.y);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_long   <= long_c;
      s2_short  <= short_c;
      s2_inside <= inside_c;
    end
  end

  // Stage 3: numerator, sign and magnitude
  function automatic lane_t lane_setup(prod_t p);
    logic signed [SUM_W-1:0] num;
    lane_t l;
    num    = SUM_W'(p.p0) + SUM_W'(p.p1);
    l.neg  = num[SUM_W-1];
    l.nq   = l.neg ? MAG_W'(-num) : MAG_W'(num);
    l.rem  = '0;
    l.den  = p.den;
    l.zero = (p.den == '0);
    l.x0   = p.x0;
    return l;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_pipe.valid <= 1'b0;
    end else if (adv) begin
      out_pipe.valid      <= s2_valid;
      out_pipe.row_in     <= s2_inside;
      out_pipe.long_lane  <= lane_setup(s2_long);
      out_pipe.short_lane <= lane_setup(s2_short);
    end
  end

endmodule

@@ rtl/tss_div_cell.sv @@
// ----------------------------------------------------------------------------
// tss_div_cell: one restoring-division step for both edges
// Produces one quotient bit per edge and hands the record to the next cell.
// ----------------------------------------------------------------------------
module tss_div_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  tss_pkg::pipe_t in_pipe,
  output tss_pkg::pipe_t out_pipe
);
  import tss_pkg::*;

  function automatic lane_t div_step(lane_t l);
    logic [REM_W-1:0] rem_sh;
    logic             qbit;
    lane_t            r;
    r      = l;
    rem_sh = {l.rem[REM_W-2:0], l.nq[MAG_W-1]};
    qbit   = (rem_sh >= REM_W'(l.den));
    r.rem  = qbit ? (rem_sh - REM_W'(l.den)) : rem_sh;
    r.nq   = {l.nq[MAG_W-2:0], qbit};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_pipe.valid <= 1'b0;
    end else if (adv) begin
      out_pipe.valid      <= in_pipe.valid;
      out_pipe.row_in     <= in_pipe.row_in;
      out_pipe.long_lane  <= div_step(in_pipe.long_lane);
      out_pipe.short_lane <= div_step(in_pipe.short_lane);
    end
  end

endmodule

@@ rtl/tss_back.sv @@
// ----------------------------------------------------------------------------
// tss_back: sign restore, saturation and output register
// Turns finished quotients into clamped span endpoints.
// ----------------------------------------------------------------------------
module tss_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           adv,
  input  tss_pkg::pipe_t in_pipe,
  output logic           out_valid,
  output tss_pkg::res_t  out_res
);
  import tss_pkg::*;

  function automatic coord_t finish(lane_t l);
    logic signed [VAL_W-1:0] v;
    coord_t                  r;
    v = l.neg ? -$signed({1'b0, l.nq}) : $signed({1'b0, l.nq});
    if (l.zero) begin
      r = l.x0;
    end else if (v > SAT_HI) begin
      r = SAT_HI[COORD_BITS-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[COORD_BITS-1:0];
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_pipe.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res.row_inside   <= in_pipe.row_in;
      out_res.long_edge_x  <= finish(in_pipe.long_lane);
      out_res.short_edge_x <= finish(in_pipe.short_lane);
    end
  end

endmodule

@@ rtl/triangle_scanline_span_top.sv @@
// ----------------------------------------------------------------------------
// triangle_scanline_span_top: scanline span generator for a filled triangle
// Sorts three vertices by y and gives the row flag and both span endpoints.
// ----------------------------------------------------------------------------
// The request channel carries three vertices and one scanline row. The result
// channel returns one result per request: whether the row lies between the
// top and bottom vertex, the x where the row meets the long edge, and the x
// where it meets the short edge on its side of the middle vertex. Each x is
// the exact crossing truncated toward zero and clamped to the coordinate range.
//
// The datapath is a single pipeline: three setup stages (sort, multiply,
// numerator), a chain of 2*COORD_BITS+3 division cells, each resolving one
// quotient bit for both edges, and an output register. While the result side is not
// stalled, one request enters per cycle, so throughput is one result per cycle.
//
// The whole pipeline advances together. While a result waits in the output
// register and the receiver holds ready low, the pipeline freezes and the
// request channel shows ready low; nothing is dropped. Reset clears all valid
// bits, so the block comes out of reset empty and ready.
// ----------------------------------------------------------------------------
module triangle_scanline_span_top (
  input logic      clk,
  input logic      rst,
  tss_in_if.sink   request,
  tss_out_if.source result
);
  import tss_pkg::*;

  logic  adv;
  pipe_t chain [NUM_CELLS+1];

  // Advance whenever the output register is empty or being emptied.
  assign adv           = !result.valid || result.ready;
  assign request.ready = adv;

  tss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (request.valid),
    .in_req   (request.payload),
    .out_pipe (chain[0])
  );

  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    tss_div_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .adv      (adv),
      .in_pipe  (chain[i]),
      .out_pipe (chain[i+1])
    );
  end

  tss_back u_back (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_pipe   (chain[NUM_CELLS]),
    .out_valid (result.valid),
    .out_res   (result.payload)
  );

endmodule

@@ rtl/tss_checker.sv @@
// ----------------------------------------------------------------------------
// tss_checker: port-level checks for the span generator
// Watches the handshakes of both channels on the top level.
// ----------------------------------------------------------------------------
module tss_checker (
  input logic          clk,
  input logic          rst,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input tss_pkg::res_t out_res
);

  // A held result stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result withdrawn while stalled");

  // A held result keeps its value.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_res))
    else $error("result changed while stalled");

  // The block takes requests exactly when its output side can move.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("request ready does not follow result side");

  // The block comes out of reset empty.
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind triangle_scanline_span_top tss_checker u_tss_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (request.valid),
  .in_ready  (request.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_res   (result.payload)
);
